### src/assert_macros.svh
// assertion macros shared by the nonzero coordinate stream modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define NCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ncs_pkg.sv
// shared types and constants of the nonzero coordinate stream
package ncs_pkg;

  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_COORD_WIDTH = 16;

  localparam int NUM_COORDS  = 4;
  localparam int COORD_OUT_W = 16;
  localparam int COUNT_W     = 31;
  localparam int EXTENT_W    = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int FMT_W       = 2;
  localparam int DIMS_W      = 3;

  localparam logic [COUNT_W-1:0] SAT31 = {COUNT_W{1'b1}};

  // element formats
  localparam logic [FMT_W-1:0] FMT_INT  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_FP32 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_FP16 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_BF16 = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_3       = 3'd5;

  // result kinds
  localparam logic KIND_COORD = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] value;
    logic        tensor_end;
  } in_item_t;

  typedef struct packed {
    logic                   kind;
    logic [COORD_OUT_W-1:0] coord_0;
    logic [COORD_OUT_W-1:0] coord_1;
    logic [COORD_OUT_W-1:0] coord_2;
    logic [COORD_OUT_W-1:0] coord_3;
    logic [COUNT_W-1:0]     flat_index;
    logic [COUNT_W-1:0]     match_count;
    logic                   run_end;
  } out_item_t;

  // classified item waiting for the back end
  typedef struct packed {
    logic                                   has_coord;
    logic                                   has_count;
    logic [NUM_COORDS-1:0][COORD_OUT_W-1:0] coords;
    logic [COUNT_W-1:0]                     flat_index;
    logic [COUNT_W-1:0]                     match_count;
  } job_t;

endpackage

### src/nonzero_coordinate_stream_top.sv
// top level of the nonzero coordinate stream
// an accepted item is written into the job queue, and its results leave through the back end's output register
// throughput: one item per cycle while the job queue is not full (in_stall); an item with a coordinate and a count
// gives two results, a four-entry job queue absorbs the difference
// the odometer carry over the used dimensions settles combinationally and does not hold the input
// reset (synchronous, rst_n low): counters clear, queue empties, config to defaults
module nonzero_coordinate_stream_top #(
  parameter int MAX_DIMS    = ncs_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH = ncs_pkg::DEF_COORD_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ncs_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ncs_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ncs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ncs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  ncs_pkg::job_t q_push_job;
  ncs_pkg::job_t q_head;

  ncs_front #(
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_job  (q_push_job)
  );

  ncs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ncs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### src/ncs_queue.sv
// job queue between front end and back end
`include "assert_macros.svh"

module ncs_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ncs_pkg::job_t push_job,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output ncs_pkg::job_t head
);

  ncs_pkg::job_t                        entries_r [ncs_pkg::QUEUE_DEPTH];
  logic [ncs_pkg::QUEUE_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ncs_pkg::QUEUE_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ncs_pkg::QUEUE_CNT_W-1:0]      count_r, count_nxt;

  assign full      = (count_r == ncs_pkg::QUEUE_CNT_W'(ncs_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  `NCS_ASSERT(a_no_pop_empty, pop |-> count_r != '0, "queue popped while empty")
  `NCS_ASSERT(a_no_push_full, push |-> !full, "queue pushed while full")

endmodule

### src/ncs_front.sv
// front end: config registers, nonzero test, odometer and job building
`include "assert_macros.svh"

module ncs_front #(
  parameter int MAX_DIMS    = ncs_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH = ncs_pkg::DEF_COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ncs_pkg::in_item_t                in_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ncs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ncs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_full,
  output logic                             push,
  output ncs_pkg::job_t                    push_job
);

  localparam int LIM_W = ((COORD_WIDTH > ncs_pkg::EXTENT_W) ? COORD_WIDTH
                                                            : ncs_pkg::EXTENT_W) + 1;
  localparam logic [LIM_W-1:0] CAP = LIM_W'(1) << COORD_WIDTH;

  logic [ncs_pkg::FMT_W-1:0]    fmt_r;
  logic [ncs_pkg::DIMS_W-1:0]   dim_count_r;
  logic [ncs_pkg::EXTENT_W-1:0] extent_r [ncs_pkg::NUM_COORDS];

  logic [ncs_pkg::COUNT_W-1:0]  position_r, position_nxt;
  logic [ncs_pkg::COUNT_W-1:0]  matches_r, matches_nxt, matches_inc;
  logic [COORD_WIDTH-1:0]       cnt_r [MAX_DIMS];
  logic [COORD_WIDTH-1:0]       cnt_nxt [MAX_DIMS];

  logic                         accept;
  logic                         nonzero;
  logic [ncs_pkg::DIMS_W-1:0]   d_used;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_comb begin
    case (fmt_r)
      ncs_pkg::FMT_INT:  nonzero = (in_item.value != '0);
      ncs_pkg::FMT_FP32: nonzero = (in_item.value[30:0] != '0);
      ncs_pkg::FMT_FP16,
      ncs_pkg::FMT_BF16: nonzero = (in_item.value[14:0] != '0);
      default:           nonzero = 1'b0;
    endcase
  end

  always_comb begin
    if (dim_count_r == '0) begin
      d_used = ncs_pkg::DIMS_W'(1);
    end else if (int'(dim_count_r) > MAX_DIMS) begin
      d_used = ncs_pkg::DIMS_W'(MAX_DIMS);
    end else begin
      d_used = dim_count_r;
    end
  end

  // odometer: innermost used counter steps, carries ripple outward
  always_comb begin
    logic             carry;
    logic             inc;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] nxt;
    logic             wrap;
    carry = 1'b0;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      cnt_nxt[k] = cnt_r[k];
      inc  = (k == int'(d_used) - 1) ? 1'b1 : ((k < int'(d_used)) && carry);
      lim  = LIM_W'(extent_r[k]);
      if (lim > CAP) begin
        lim = CAP;
      end
      nxt  = LIM_W'(cnt_r[k]) + LIM_W'(1);
      wrap = (nxt >= lim);
      if (inc) begin
        cnt_nxt[k] = wrap ? '0 : nxt[COORD_WIDTH-1:0];
      end
      carry = inc && wrap;
    end
  end

  always_comb begin
    position_nxt = (position_r != ncs_pkg::SAT31) ? position_r + 1'b1 : position_r;
    matches_inc  = (nonzero && matches_r != ncs_pkg::SAT31) ? matches_r + 1'b1
                                                           : matches_r;
    matches_nxt  = matches_inc;
  end

  always_comb begin
    push_job             = '0;
    push_job.has_coord   = nonzero;
    push_job.has_count   = in_item.tensor_end;
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (j < int'(d_used)) begin
        push_job.coords[j] = ncs_pkg::COORD_OUT_W'(cnt_r[j]);
      end
    end
    push_job.flat_index  = position_r;
    push_job.match_count = matches_inc;
    push = accept && (nonzero || in_item.tensor_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= ncs_pkg::FMT_INT;
      dim_count_r <= ncs_pkg::DIMS_W'(1);
      for (int k = 0; k < ncs_pkg::NUM_COORDS; k++) begin
        extent_r[k] <= ncs_pkg::EXTENT_W'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ncs_pkg::CFG_ELEMENT_FORMAT: fmt_r       <= cfg_data[ncs_pkg::FMT_W-1:0];
        ncs_pkg::CFG_DIM_COUNT:      dim_count_r <= cfg_data[ncs_pkg::DIMS_W-1:0];
        ncs_pkg::CFG_EXTENT_0:       extent_r[0] <= cfg_data;
        ncs_pkg::CFG_EXTENT_1:       extent_r[1] <= cfg_data;
        ncs_pkg::CFG_EXTENT_2:       extent_r[2] <= cfg_data;
        ncs_pkg::CFG_EXTENT_3:       extent_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      matches_r  <= '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (accept) begin
      if (in_item.tensor_end) begin
        position_r <= '0;
        matches_r  <= '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
          cnt_r[k] <= '0;
        end
      end else begin
        position_r <= position_nxt;
        matches_r  <= matches_nxt;
        for (int k = 0; k < MAX_DIMS; k++) begin
          cnt_r[k] <= cnt_nxt[k];
        end
      end
    end
  end

  `NCS_ASSERT(a_end_clears, accept && in_item.tensor_end |=> position_r == '0 && matches_r == '0, "counters not cleared after tensor end")

endmodule

### src/ncs_back.sv
// back end: expands queued jobs into result items behind an output register
`include "assert_macros.svh"

module ncs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ncs_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ncs_pkg::out_item_t out_item
);

  logic               out_valid_r, out_valid_nxt;
  ncs_pkg::out_item_t out_item_r, out_item_nxt;
  logic               sent_r, sent_nxt;
  logic               load;
  logic               take;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign load      = !out_valid_r || !out_stall;
  assign take      = load && q_valid;

  always_comb begin
    out_item_nxt  = '0;
    q_pop         = 1'b0;
    sent_nxt      = sent_r;
    out_valid_nxt = load ? take : out_valid_r;
    if (take) begin
      if (q_job.has_coord && !sent_r) begin
        out_item_nxt.kind       = ncs_pkg::KIND_COORD;
        out_item_nxt.coord_0    = q_job.coords[0];
        out_item_nxt.coord_1    = q_job.coords[1];
        out_item_nxt.coord_2    = q_job.coords[2];
        out_item_nxt.coord_3    = q_job.coords[3];
        out_item_nxt.flat_index = q_job.flat_index;
        out_item_nxt.run_end    = !q_job.has_count;
        // count result still to come for this item
        if (q_job.has_count) begin
          sent_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        out_item_nxt.kind        = ncs_pkg::KIND_COUNT;
        out_item_nxt.match_count = q_job.match_count;
        out_item_nxt.run_end     = 1'b1;
        q_pop    = 1'b1;
        sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= out_item_nxt;
    end
  end

  `NCS_ASSERT(a_sent_has_job, sent_r |-> q_valid, "half-sent job missing from queue head")
  `NCS_ASSERT(a_count_ends_run, out_valid_r && out_item_r.kind == ncs_pkg::KIND_COUNT |-> out_item_r.run_end, "count result without run end")
  `NCS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && !sent_r, "back end not idle after reset")

endmodule

### verif/ncs_checker.sv
`timescale 1ns / 1ps
// checker that predicts and compares the coordinate and count results of the nonzero stream
module ncs_checker
  import ncs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int REPORT_LIMIT = 100;
  localparam logic [EXTENT_W-1:0] COORD_CAP = EXTENT_W'(1) << DEF_COORD_WIDTH;

  logic [FMT_W-1:0]       fmt;
  logic [DIMS_W-1:0]      dims_reg;
  logic [EXTENT_W-1:0]    extent [NUM_COORDS];
  logic [COUNT_W-1:0]     position;
  logic [COUNT_W-1:0]     match_total;
  logic [COORD_OUT_W-1:0] odometer [NUM_COORDS];
  out_item_t              results_due [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic is_nonzero(logic [31:0] v);
    case (fmt)
      FMT_INT:  return v != '0;
      FMT_FP32: return v[30:0] != '0;
      default:  return v[14:0] != '0;
    endcase
  endfunction

  function automatic int dims_in_use();
    if (dims_reg == '0) return 1;
    if (dims_reg > DEF_MAX_DIMS) return DEF_MAX_DIMS;
    return int'(dims_reg);
  endfunction

  task automatic clear_tensor();
    int k;
    position    = '0;
    match_total = '0;
    for (k = 0; k < NUM_COORDS; k++) odometer[k] = '0;
  endtask

  // innermost dimension counts first, carry moves outward
  task automatic step_odometer();
    int k;
    logic [EXTENT_W-1:0] lim;
    logic [EXTENT_W-1:0] nxt;
    bit carry;
    if (position != SAT31) position = position + 1'b1;
    carry = 1'b1;
    for (k = dims_in_use() - 1; k >= 0 && carry; k--) begin
      lim = (extent[k] > COORD_CAP) ? COORD_CAP : extent[k];
      nxt = {1'b0, odometer[k]} + 1'b1;
      if (nxt >= lim) begin
        odometer[k] = '0;
      end else begin
        odometer[k] = nxt[COORD_OUT_W-1:0];
        carry = 1'b0;
      end
    end
  endtask

  task automatic track_element(in_item_t it);
    out_item_t r;
    logic [COORD_OUT_W-1:0] c [NUM_COORDS];
    int d;
    int j;
    d = dims_in_use();
    if (is_nonzero(it.value)) begin
      for (j = 0; j < NUM_COORDS; j++) c[j] = (j < d) ? odometer[j] : '0;
      r = '0;
      r.kind       = KIND_COORD;
      r.coord_0    = c[0];
      r.coord_1    = c[1];
      r.coord_2    = c[2];
      r.coord_3    = c[3];
      r.flat_index = position;
      r.run_end    = !it.tensor_end;
      if (match_total != SAT31) match_total = match_total + 1'b1;
      results_due.push_back(r);
    end
    step_odometer();
    if (it.tensor_end) begin
      r = '0;
      r.kind        = KIND_COUNT;
      r.match_count = match_total;
      r.run_end     = 1'b1;
      results_due.push_back(r);
      clear_tensor();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: result with none pending, expected nothing, got %h", $time, got);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("coord_0", want.coord_0, got.coord_0);
    check_field("coord_1", want.coord_1, got.coord_1);
    check_field("coord_2", want.coord_2, got.coord_2);
    check_field("coord_3", want.coord_3, got.coord_3);
    check_field("flat_index", want.flat_index, got.flat_index);
    check_field("match_count", want.match_count, got.match_count);
    check_field("run_end", want.run_end, got.run_end);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fmt      = FMT_INT;
      dims_reg = DIMS_W'(1);
      for (int k = 0; k < NUM_COORDS; k++) extent[k] = EXTENT_W'(1);
      clear_tensor();
      results_due.delete();
    end else begin
      // a result never comes out at the edge its item goes in
      if (out_valid === 1'b1 && out_stall === 1'b0) compare_result(out_item);
      // an item taken at the same edge as a config write still sees the old config
      if (in_valid === 1'b1 && in_stall === 1'b0) track_element(in_item);
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_ELEMENT_FORMAT: fmt = cfg_data[FMT_W-1:0];
          CFG_DIM_COUNT:      dims_reg = cfg_data[DIMS_W-1:0];
          CFG_EXTENT_0:       extent[0] = cfg_data[EXTENT_W-1:0];
          CFG_EXTENT_1:       extent[1] = cfg_data[EXTENT_W-1:0];
          CFG_EXTENT_2:       extent[2] = cfg_data[EXTENT_W-1:0];
          CFG_EXTENT_3:       extent[3] = cfg_data[EXTENT_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= results_due.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// top of the nonzero stream testbench: clock, reset, stimulus and verdict
module testbench;
  import ncs_pkg::*;

  localparam int ITEM_TARGET = 1820;
  localparam int HOLD_OFF_LEN = 40;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int hold_off_asks = 0;
  int hold_off_done = 0;
  bit steady = 1'b0;

  int                  cur_dims = 1;
  logic [EXTENT_W-1:0] cur_extent [NUM_COORDS] = '{default: EXTENT_W'(1)};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  nonzero_coordinate_stream_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ncs_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  task automatic send_item(input logic [31:0] v, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item.value <= v;
    in_item.tensor_end <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // the extra edges cover an item with no result still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [FMT_W-1:0] f, input logic [DIMS_W-1:0] d,
                              input logic [EXTENT_W-1:0] e0, input logic [EXTENT_W-1:0] e1,
                              input logic [EXTENT_W-1:0] e2, input logic [EXTENT_W-1:0] e3);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    int i;
    idx[0] = CFG_ELEMENT_FORMAT; val[0] = CFG_DATA_W'(f);
    idx[1] = CFG_DIM_COUNT;      val[1] = CFG_DATA_W'(d);
    idx[2] = CFG_EXTENT_0;       val[2] = e0;
    idx[3] = CFG_EXTENT_1;       val[3] = e1;
    idx[4] = CFG_EXTENT_2;       val[4] = e2;
    idx[5] = CFG_EXTENT_3;       val[5] = e3;
    cfg_valid <= 1'b1;
    for (i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    cur_dims = (d == '0) ? 1 : (d > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(d);
    cur_extent[0] = e0;
    cur_extent[1] = e1;
    cur_extent[2] = e2;
    cur_extent[3] = e3;
  endtask

  function automatic logic [EXTENT_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return EXTENT_W'(32'h10000);
      2:       return EXTENT_W'($urandom_range(32'h10001, 32'h1FFFF));
      3:       return EXTENT_W'($urandom_range(5, 300));
      default: return EXTENT_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic longint eff_extent(logic [EXTENT_W-1:0] e);
    if (e == '0) return 1;
    if (e > EXTENT_W'(32'h10000)) return 65536;
    return longint'(e);
  endfunction

  // zeros, signed zeros of every format, small values and fully random bits
  function automatic logic [31:0] element_bits();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'h8000_0000;
      2:       return {16'($urandom()), 16'h0000};
      3:       return {16'($urandom()), 16'h8000};
      4:       return 32'($urandom_range(0, 32'h7FFF));
      default: return $urandom();
    endcase
  endfunction

  // whole tensors up to 64 elements, else random lengths; sometimes cut short, run past the extents or left open
  task automatic run_tensor(input bit leave_open);
    longint span;
    int len;
    int i;
    span = 1;
    for (i = 0; i < cur_dims; i++) span *= eff_extent(cur_extent[i]);
    len = (span <= 64) ? int'(span) : $urandom_range(1, 48);
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(1, len);
      1:       len = len + $urandom_range(1, 6);
      default: ;
    endcase
    for (i = 1; i <= len; i++) send_item(element_bits(), !leave_open && i == len);
  endtask

  initial begin : drain_results
    int stall_len;
    forever begin
      if (hold_off_done != hold_off_asks) begin
        stall_len = HOLD_OFF_LEN;
        hold_off_done++;
      end else begin
        stall_len = steady ? 0 : $urandom_range(0, 3);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int t;
    int tensors;
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: integer format, one dimension of extent one
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    wait_idle();
    // dim count above max, a zero extent and an extent above the counter range
    apply_config(FMT_FP32, 3'd7, 17'd2, 17'd0, 17'h1FFFF, 17'd2);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FC0_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFF80_0000, 1'b0);
    send_item(32'h0000_8000, 1'b0);
    wait_idle();
    // format and shape change with the tensor still open, dim count zero
    apply_config(FMT_FP16, 3'd0, 17'd3, 17'd1, 17'd1, 17'd1);
    send_item(32'hFFFF_8000, 1'b0);
    send_item(32'h0000_7C00, 1'b0);
    send_item(32'h0001_0001, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_FFFF, 1'b1);
    wait_idle();
    apply_config(FMT_BF16, 3'd4, 17'h10000, 17'd1, 17'd2, 17'd2);
    send_item(32'h8000_8000, 1'b0);
    send_item(32'h0000_3F80, 1'b0);
    send_item(32'hFFFF_0000, 1'b0);
    send_item(32'h0000_0080, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_7FFF, 1'b1);
    // empty tensor: only the count item
    send_item(32'h0000_0000, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      steady = 1'b0;
      apply_config(FMT_W'($urandom_range(0, 3)),
                   ($urandom_range(0, 1) == 0) ? DIMS_W'($urandom_range(0, 7))
                                               : DIMS_W'($urandom_range(1, 4)),
                   pick_extent(), pick_extent(), pick_extent(), pick_extent());
      steady = ($urandom_range(0, 3) == 0);
      // receiver holds off while a burst of nonzero items fills the block
      if (phase == 2 || $urandom_range(0, 14) == 0) begin
        hold_off_asks++;
        for (i = 0; i < 16; i++) send_item($urandom() | 32'h1, 1'b0);
      end
      tensors = $urandom_range(1, 4);
      for (t = 0; t < tensors; t++)
        run_tensor(t == tensors - 1 && $urandom_range(0, 4) == 0);
      phase++;
    end

    steady = 1'b0;
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### nonzero_coordinate_stream_top.f
+incdir+src
src/ncs_pkg.sv
src/ncs_queue.sv
src/ncs_front.sv
src/ncs_back.sv
src/nonzero_coordinate_stream_top.sv
verif/ncs_checker.sv
verif/testbench.sv
